### hdl/pdf_pkg.sv
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types and constants of the preamble frame deframer.
// ----------------------------------------------------------------------------
package pdf_pkg;

  localparam int BYTE_W    = 8;
  localparam int PLEN_W    = 4;
  localparam int IDX_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_LIMIT = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE    = 1'd1;

  localparam logic [PLEN_W-1:0] PREAMBLE_LEN_RST = 4'd5;
  localparam logic [BYTE_W-1:0] SYNC_BYTE_RST    = 8'hFF;
  localparam logic [PLEN_W-1:0] SYNC_RUN_MAX     = 4'd15;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic sync_upd;
    logic cap_func;
    logic cap_len;
    logic cap_data;
    logic cap_check;
    logic rd_start;
    logic rd_issue;
    logic rd_next;
    logic out_load;
  } pdf_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic len_zero;
    logic data_done;
    logic empty;
    logic rd_last;
    logic out_free;
  } pdf_status_t;

endpackage

### hdl/pdf_ctrl.sv
// ----------------------------------------------------------------------------
// pdf_ctrl
// Frame phase controller: preamble hunt, header, payload, checksum, readout.
// ----------------------------------------------------------------------------
module pdf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pdf_pkg::pdf_status_t status,
  output pdf_pkg::pdf_cmd_t    cmd
);
  import pdf_pkg::*;

  localparam logic [2:0] ST_PRE     = 3'd0;
  localparam logic [2:0] ST_FUNC    = 3'd1;
  localparam logic [2:0] ST_LEN     = 3'd2;
  localparam logic [2:0] ST_DATA    = 3'd3;
  localparam logic [2:0] ST_CHECK   = 3'd4;
  localparam logic [2:0] ST_EMIT_RD = 3'd5;
  localparam logic [2:0] ST_EMIT_LD = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       take;

  assign in_stall = (state_r == ST_EMIT_RD) || (state_r == ST_EMIT_LD);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_PRE: begin
        if (take) begin
          cmd.sync_upd = 1'b1;
          if (status.sync_hit) state_nxt = ST_FUNC;
        end
      end
      ST_FUNC: begin
        if (take) begin
          cmd.cap_func = 1'b1;
          state_nxt    = ST_LEN;
        end
      end
      ST_LEN: begin
        if (take) begin
          cmd.cap_len = 1'b1;
          state_nxt   = status.len_zero ? ST_CHECK : ST_DATA;
        end
      end
      ST_DATA: begin
        if (take) begin
          cmd.cap_data = 1'b1;
          if (status.data_done) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (take) begin
          cmd.cap_check = 1'b1;
          cmd.rd_start  = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.rd_issue = !status.empty;
        state_nxt    = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.empty || status.rd_last) begin
            state_nxt = ST_PRE;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_PRE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PRE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/pdf_dpath.sv
// ----------------------------------------------------------------------------
// pdf_dpath
// Config registers, sync run counter, header capture, payload buffer and
// output register.
// ----------------------------------------------------------------------------
module pdf_dpath #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdf_pkg::BYTE_W-1:0]        cfg_wr_data,
  input  logic [pdf_pkg::BYTE_W-1:0]        in_rx_byte,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [pdf_pkg::BYTE_W-1:0]        out_func_code,
  output logic [pdf_pkg::BYTE_W-1:0]        out_frame_length,
  output logic [pdf_pkg::BYTE_W-1:0]        out_check_byte,
  output logic [pdf_pkg::BYTE_W-1:0]        out_payload_byte,
  output logic [pdf_pkg::IDX_W-1:0]         out_payload_index,
  output logic                              out_has_data,
  output logic                              out_truncated,
  output logic                              out_last,
  input  pdf_pkg::pdf_cmd_t                 cmd,
  output pdf_pkg::pdf_status_t              status
);
  import pdf_pkg::*;

  localparam int          AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [7:0]  DEPTH_B = 8'(DEPTH);

  logic [PLEN_W-1:0] preamble_len_r;
  byte_t             sync_byte_r;
  logic [PLEN_W-1:0] sync_run_r;
  logic [PLEN_W-1:0] sync_run_nxt;
  logic [PLEN_W-1:0] need;
  byte_t             held_func_r;
  byte_t             held_length_r;
  byte_t             held_check_r;
  byte_t             byte_count_r;
  logic [IDX_W-1:0]  rd_idx_r;
  byte_t             rd_data_r;
  byte_t             stored;
  logic              trunc;

  byte_t             mem [DEPTH];

  logic              out_valid_r;
  byte_t             out_func_r;
  byte_t             out_len_r;
  byte_t             out_check_r;
  byte_t             out_payload_r;
  logic [IDX_W-1:0]  out_index_r;
  logic              out_has_data_r;
  logic              out_trunc_r;
  logic              out_last_r;

  // sync run tracking
  assign need = (preamble_len_r == '0) ? 4'd1 : preamble_len_r;
  always_comb begin
    if (in_rx_byte == sync_byte_r) begin
      sync_run_nxt = (sync_run_r == SYNC_RUN_MAX) ? SYNC_RUN_MAX : sync_run_r + 4'd1;
    end else begin
      sync_run_nxt = '0;
    end
  end

  assign trunc  = held_length_r > DEPTH_B;
  assign stored = trunc ? DEPTH_B : held_length_r;

  assign status.sync_hit  = sync_run_nxt >= need;
  assign status.len_zero  = in_rx_byte == '0;
  assign status.data_done = (byte_count_r + 8'd1) >= held_length_r;
  assign status.empty     = stored == '0;
  assign status.rd_last   = {3'b000, rd_idx_r} == (stored - 8'd1);
  assign status.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_len_r <= PREAMBLE_LEN_RST;
      sync_byte_r    <= SYNC_BYTE_RST;
      sync_run_r     <= '0;
      held_func_r    <= '0;
      held_length_r  <= '0;
      byte_count_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_PREAMBLE_LEN: preamble_len_r <= cfg_wr_data[PLEN_W-1:0];
          CFG_SYNC_BYTE:    sync_byte_r    <= cfg_wr_data;
          default:          ;
        endcase
      end
      if (cmd.sync_upd) sync_run_r <= status.sync_hit ? '0 : sync_run_nxt;
      if (cmd.cap_func) held_func_r <= in_rx_byte;
      if (cmd.cap_len) begin
        held_length_r <= in_rx_byte;
        byte_count_r  <= '0;
      end
      if (cmd.cap_data) byte_count_r <= byte_count_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_check) held_check_r <= in_rx_byte;
    if (cmd.rd_start) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_next) begin
      rd_idx_r <= rd_idx_r + 5'd1;
    end
  end

  // payload buffer
  always_ff @(posedge clk) begin
    if (cmd.cap_data && (byte_count_r < DEPTH_B)) begin
      mem[byte_count_r[AW-1:0]] <= in_rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_func_r     <= held_func_r;
      out_len_r      <= held_length_r;
      out_check_r    <= held_check_r;
      out_payload_r  <= status.empty ? '0 : rd_data_r;
      out_index_r    <= status.empty ? '0 : rd_idx_r;
      out_has_data_r <= !status.empty;
      out_trunc_r    <= trunc;
      out_last_r     <= status.empty || status.rd_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_func_code     = out_func_r;
  assign out_frame_length  = out_len_r;
  assign out_check_byte    = out_check_r;
  assign out_payload_byte  = out_payload_r;
  assign out_payload_index = out_index_r;
  assign out_has_data      = out_has_data_r;
  assign out_truncated     = out_trunc_r;
  assign out_last          = out_last_r;

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while a result waits");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> ({3'b000, rd_idx_r} < stored))
    else $error("buffer read beyond stored payload");

  a_data_within_length: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_data |-> (byte_count_r < held_length_r))
    else $error("payload byte taken beyond frame length");

  a_run_cleared_on_open: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_func |-> (sync_run_r == '0))
    else $error("sync run not cleared when frame opened");

endmodule

### hdl/preamble_frame_deframer.sv
// ----------------------------------------------------------------------------
// preamble_frame_deframer
// Hunts for a run of sync bytes, collects function code, length, payload
// and checksum, then plays the frame out one payload byte per result (one result without payload for an empty frame).
//
//   channel  | direction | handshake          | payload
//   in_      | input     | in_valid/in_stall  | in_rx_byte
//   out_     | output    | out_valid/out_stall| header, payload byte, flags
//   cfg_     | input     | cfg_wr_en          | cfg_index, cfg_wr_data
//
// one received byte is taken per cycle while the frame is collected
// the checksum byte starts readout: each result is a buffer read, then an
// output register load, and in_stall is held until the last result of the
// frame is loaded, also for an empty frame
// synchronous active-low reset; no clearing pass, the buffer is written
// before it is read in every frame
// out_stall holds the output register and pauses readout
// ----------------------------------------------------------------------------
module preamble_frame_deframer #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdf_pkg::BYTE_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pdf_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pdf_pkg::BYTE_W-1:0]     out_func_code,
  output logic [pdf_pkg::BYTE_W-1:0]     out_frame_length,
  output logic [pdf_pkg::BYTE_W-1:0]     out_check_byte,
  output logic [pdf_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic [pdf_pkg::IDX_W-1:0]      out_payload_index,
  output logic                           out_has_data,
  output logic                           out_truncated,
  output logic                           out_last
);
  import pdf_pkg::*;

  localparam int KEEP = (MAX_PAYLOAD < OUT_LIMIT) ? MAX_PAYLOAD : OUT_LIMIT;

  pdf_cmd_t    cmd;
  pdf_status_t status;

  pdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pdf_dpath #(
    .DEPTH (KEEP)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .in_rx_byte        (in_rx_byte),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_func_code     (out_func_code),
    .out_frame_length  (out_frame_length),
    .out_check_byte    (out_check_byte),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_has_data      (out_has_data),
    .out_truncated     (out_truncated),
    .out_last          (out_last),
    .cmd               (cmd),
    .status            (status)
  );

endmodule
